// File: rtl/core/tcp_pkg.sv
// Package for the text command parser: command and modifier codes, shared structs,
// constants and the stop-word character table.
// No dependencies.
package tcp_pkg;

	typedef enum logic [2:0] {
		KIND_LINEAR  = 3'd0,
		KIND_STOP    = 3'd1,
		KIND_DEVICE  = 3'd2,
		KIND_VERSION = 3'd3,
		KIND_AXES    = 3'd4
	} cmd_kind_t;

	typedef enum logic [1:0] {
		MOD_NONE     = 2'd0,
		MOD_INTERVAL = 2'd1,
		MOD_SPEED    = 2'd2
	} mod_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		mod_kind_t modk;
	} tcp_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic ovf;
	} tcp_div_stat_t;

	localparam logic [16:0] FULL_Q16      = 17'd65536;
	localparam logic [19:0] DUR_MAX       = 20'd1048575;
	localparam logic [16:0] SPEED_NUM     = 17'd100000;
	localparam logic [19:0] MAG_MAX_RESET = 20'd999;
	localparam logic [2:0]  STOP_LEN      = 3'd5;

	function automatic logic [7:0] stop_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = "D";
			3'd1: ch = "S";
			3'd2: ch = "T";
			3'd3: ch = "O";
			3'd4: ch = "P";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: rtl/core/tcp_front.sv
// Front end of the text command parser: takes one character per word, tracks the token
// and pushes a command descriptor into the queue when a token ends.
// Depends on tcp_pkg.
module tcp_front
	import tcp_pkg::*;
#(
	parameter int ACC_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // text_byte
	input  logic                s_tlast,   // frame_end
	input  logic                full,
	output logic                push,
	output tcp_ctl_t            push_ctl,
	output logic [ACC_BITS-1:0] push_mag,
	output logic [ACC_BITS-1:0] push_mod
);

	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_SKIP    = 9'b000000010,
		PH_LCHAN   = 9'b000000100,
		PH_LMAG    = 9'b000001000,
		PH_LMOD    = 9'b000010000,
		PH_LTAIL   = 9'b000100000,
		PH_DSECOND = 9'b001000000,
		PH_DMATCH  = 9'b010000000,
		PH_DREST   = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		TOK_NONE   = 2'd0,
		TOK_DEVICE = 2'd1,
		TOK_LINEAR = 2'd2
	} tok_kind_t;

	function automatic logic [ACC_BITS-1:0] acc_push(input logic [ACC_BITS-1:0] acc,
			input logic [3:0] dig);
		logic [ACC_BITS+3:0] wide;
		logic [ACC_BITS+3:0] v;
		wide = (ACC_BITS+4)'(acc);
		v = (wide << 3) + (wide << 1) + (ACC_BITS+4)'(dig);
		if (v > (ACC_BITS+4)'({ACC_BITS{1'b1}}))
			return {ACC_BITS{1'b1}};
		return v[ACC_BITS-1:0];
	endfunction

	phase_t              ph_q, ph_n;
	tok_kind_t           tok_q, tok_n;
	logic [2:0]          stp_q, stp_n;
	logic [ACC_BITS-1:0] mag_q, mag_n;
	logic                dig_q, dig_n;
	mod_kind_t           modk_q, modk_n;
	logic [ACC_BITS-1:0] modv_q, modv_n;
	logic [1:0]          qry_q, qry_n;

	logic [7:0] c;
	logic [7:0] u;
	logic       is_dig;
	logic       delim;
	logic       acc_w;
	logic       tok_end;
	logic       emit;
	cmd_kind_t  kind;

	assign c      = s_tdata;
	assign u      = (c >= "a" && c <= "z") ? c - 8'd32 : c;
	assign is_dig = (c >= "0" && c <= "9");
	assign delim  = (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a);
	assign s_tready = !full;
	assign acc_w  = s_tvalid && s_tready;

	always_comb begin
		ph_n   = ph_q;
		tok_n  = tok_q;
		stp_n  = stp_q;
		mag_n  = mag_q;
		dig_n  = dig_q;
		modk_n = modk_q;
		modv_n = modv_q;
		qry_n  = qry_q;
		if (!delim) begin
			unique case (ph_q)
				PH_IDLE: begin
					if (u == "D") begin
						tok_n = TOK_DEVICE;
						stp_n = 3'd1;
						ph_n  = PH_DSECOND;
					end else if (u == "L") begin
						tok_n = TOK_LINEAR;
						ph_n  = PH_LCHAN;
					end else begin
						tok_n = TOK_NONE;
						ph_n  = PH_SKIP;
					end
				end
				PH_LCHAN: ph_n = (c == "0") ? PH_LMAG : PH_SKIP;
				PH_LMAG: begin
					if (is_dig) begin
						mag_n = acc_push(mag_q, c[3:0]);
						dig_n = 1'b1;
					end else if (u == "I") begin
						modk_n = MOD_INTERVAL;
						ph_n   = PH_LMOD;
					end else if (u == "S") begin
						modk_n = MOD_SPEED;
						ph_n   = PH_LMOD;
					end else begin
						ph_n = PH_LTAIL;
					end
				end
				PH_LMOD: begin
					if (is_dig)
						modv_n = acc_push(modv_q, c[3:0]);
					else
						ph_n = PH_LTAIL;
				end
				PH_DSECOND: begin
					if (u == "S") begin
						stp_n = 3'd2;
						ph_n  = PH_DMATCH;
					end else begin
						if (c >= "0" && c <= "2")
							qry_n = c[1:0] + 2'd1;
						ph_n = PH_DREST;
					end
				end
				PH_DMATCH: begin
					if (stp_q < STOP_LEN && u == stop_char(stp_q)) begin
						stp_n = stp_q + 3'd1;
						if (stp_n == STOP_LEN)
							ph_n = PH_DREST;
					end else begin
						ph_n = PH_DREST;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		emit = 1'b0;
		kind = KIND_LINEAR;
		if (tok_n == TOK_DEVICE) begin
			if (stp_n == STOP_LEN) begin
				emit = 1'b1;
				kind = KIND_STOP;
			end else if (qry_n != 2'd0) begin
				emit = 1'b1;
				kind = cmd_kind_t'(3'(qry_n) + 3'd1);
			end
		end else if (tok_n == TOK_LINEAR && ph_n != PH_SKIP && ph_n != PH_LCHAN && dig_n) begin
			emit = 1'b1;
		end
	end

	assign tok_end       = delim ? (ph_q != PH_IDLE) : s_tlast;
	assign push          = acc_w && tok_end && emit;
	assign push_ctl.kind = kind;
	assign push_ctl.modk = modk_n;
	assign push_mag      = mag_n;
	assign push_mod      = modv_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			tok_q  <= TOK_NONE;
			stp_q  <= '0;
			mag_q  <= '0;
			dig_q  <= 1'b0;
			modk_q <= MOD_NONE;
			modv_q <= '0;
			qry_q  <= '0;
		end else if (acc_w) begin
			if (tok_end) begin
				ph_q   <= PH_IDLE;
				tok_q  <= TOK_NONE;
				stp_q  <= '0;
				mag_q  <= '0;
				dig_q  <= 1'b0;
				modk_q <= MOD_NONE;
				modv_q <= '0;
				qry_q  <= '0;
			end else begin
				ph_q   <= ph_n;
				tok_q  <= tok_n;
				stp_q  <= stp_n;
				mag_q  <= mag_n;
				dig_q  <= dig_n;
				modk_q <= modk_n;
				modv_q <= modv_n;
				qry_q  <= qry_n;
			end
		end
	end

endmodule

// File: rtl/core/tcp_fifo.sv
// Two-entry command queue between the parser front end and the command back end.
// Depends on tcp_pkg only for the house import convention.
module tcp_fifo
	import tcp_pkg::*;
#(
	parameter int W = 44
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	input  logic         pop,
	output logic [W-1:0] rd_data,
	output logic         full,
	output logic         empty
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !(push && !pop)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count slip");
`endif

endmodule

// File: rtl/core/tcp_div.sv
// Restoring divider, one quotient bit per cycle, with a 17-bit quotient and a sticky
// flag that is set once the quotient outgrows 17 bits. Depends on tcp_pkg.
module tcp_div
	import tcp_pkg::*;
#(
	parameter int NW = 38,
	parameter int DW = 21
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output tcp_div_stat_t stat,
	output logic [16:0]   quot
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [16:0]   quot_q;
	logic          ovf_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;

	logic [DW:0] rem_sh;
	logic [DW:0] rem_sub;
	logic        ge;

	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = (rem_sh >= {1'b0, den_q});

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
	assign quot      = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			rem_q  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quot_q <= {quot_q[15:0], ge};
			ovf_q  <= ovf_q | quot_q[16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/tcp_back.sv
// Back end of the text command parser: pops command descriptors, runs the position and
// speed divisions on tcp_div and holds the result word. Depends on tcp_pkg, tcp_div.
module tcp_back
	import tcp_pkg::*;
#(
	parameter int ACC_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	output logic                pop,
	input  tcp_ctl_t            rd_ctl,
	input  logic [ACC_BITS-1:0] rd_mag,
	input  logic [ACC_BITS-1:0] rd_mod,
	input  logic [19:0]         mag_max,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,   // position, move_ms, zero fill
	output logic [2:0]          m_tuser    // cmd_kind
);

	localparam int NW = ACC_BITS + 18;
	localparam int DW = (ACC_BITS > 21) ? ACC_BITS : 21;
	localparam int EW = (ACC_BITS > 20) ? ACC_BITS : 20;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIVP = 4'b0010,
		ST_DIVD = 4'b0100,
		ST_DONE = 4'b1000
	} st_t;

	st_t                 st_q;
	cmd_kind_t           kind_q;
	mod_kind_t           modk_q;
	logic [ACC_BITS-1:0] modv_q;
	logic [16:0]         pos_q;
	logic [19:0]         dur_q;

	logic                m_tvalid_q;
	cmd_kind_t           kind_out_q;
	logic [16:0]         pos_out_q;
	logic [19:0]         dur_out_q;

	logic [19:0]         mx;
	logic                div_start;
	logic [NW-1:0]       div_num;
	logic [DW-1:0]       div_den;
	tcp_div_stat_t       div_stat;
	logic [16:0]         div_quot;
	logic [16:0]         pos_clamp;
	logic [EW-1:0]       modv_ext;
	logic [19:0]         dur_int;
	logic                speed_go;
	logic                out_free;

	assign mx        = (mag_max == 20'd0) ? 20'd1 : mag_max;
	assign pop       = (st_q == ST_IDLE) && !empty;
	assign speed_go  = (modk_q == MOD_SPEED) && (modv_q != '0);
	assign div_start = (pop && rd_ctl.kind == KIND_LINEAR) ||
		(st_q == ST_DIVP && div_stat.done && speed_go);
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		if (st_q == ST_IDLE) begin
			div_num = {1'b0, rd_mag, 17'd0} + NW'(mx);
			div_den = DW'({mx, 1'b0});
		end else begin
			div_num = NW'(SPEED_NUM);
			div_den = DW'(modv_q);
		end
	end

	assign pos_clamp = (div_stat.ovf || div_quot > FULL_Q16) ? FULL_Q16 : div_quot;
	assign modv_ext  = EW'(modv_q);
	assign dur_int   = (modv_ext > EW'(DUR_MAX)) ? DUR_MAX : modv_ext[19:0];

	tcp_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.stat  (div_stat),
		.quot  (div_quot)
	);

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (pop) begin
					kind_q <= rd_ctl.kind;
					modk_q <= rd_ctl.modk;
					modv_q <= rd_mod;
					pos_q  <= '0;
					dur_q  <= '0;
				end
			end
			ST_DIVP: begin
				if (div_stat.done) begin
					pos_q <= pos_clamp;
					if (modk_q == MOD_INTERVAL)
						dur_q <= dur_int;
				end
			end
			ST_DIVD: begin
				if (div_stat.done)
					dur_q <= div_quot[16:0] == '0 ? 20'd0 : 20'(div_quot);
			end
			ST_DONE: begin
				if (out_free) begin
					kind_out_q <= kind_q;
					pos_out_q  <= pos_q;
					dur_out_q  <= dur_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (st_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (pop)
						st_q <= (rd_ctl.kind == KIND_LINEAR) ? ST_DIVP : ST_DONE;
				end
				ST_DIVP: begin
					if (div_stat.done)
						st_q <= speed_go ? ST_DIVD : ST_DONE;
				end
				ST_DIVD: begin
					if (div_stat.done)
						st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'd0, dur_out_q, pos_out_q};
	assign m_tuser  = kind_out_q;

`ifndef SYNTH
	a_plain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && kind_out_q != KIND_LINEAR) |-> (pos_out_q == '0 && dur_out_q == '0))
		else $error("non-move command carries position or duration");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> pos_out_q <= FULL_Q16) else $error("position above full travel");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy) else $error("divider started while busy");
`endif

endmodule

// File: rtl/core/tcode_command_parser_core.sv
// Top level of the text command parser: configuration register, parser front end,
// command queue and back end. Depends on tcp_pkg, tcp_front, tcp_fifo, tcp_back.
//
//   port group  dir  content
//   s_*         in   word = one text byte, tlast = frame end
//   m_*         out  word = position and duration, tuser = command kind
//   cfg_*       in   magnitude_max write
//
// The front end takes one byte per cycle and stalls only while the queue holds two commands.
// From pop to result word a move runs the position division on the bit-serial divider,
// and a nonzero S modifier adds the speed division after it.
// Other commands go from pop through the done state to the result word.
// Reset is asynchronous and clears the token state, the queue and the output valid.
// A stalled result word stays in the output register while the queue keeps filling.
module tcode_command_parser_core
	import tcp_pkg::*;
#(
	parameter int ACC_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // position [16:0], move_ms [36:17], zero fill
	output logic [2:0]  m_tuser,   // cmd_kind
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata  // magnitude_max
);

	localparam int QW = $bits(tcp_ctl_t) + 2 * ACC_BITS;

	logic [19:0]         mag_max_q;
	logic                push;
	tcp_ctl_t            push_ctl;
	logic [ACC_BITS-1:0] push_mag;
	logic [ACC_BITS-1:0] push_mod;
	logic                pop;
	logic                full;
	logic                empty;
	logic [QW-1:0]       rd_data;
	tcp_ctl_t            rd_ctl;
	logic [ACC_BITS-1:0] rd_mag;
	logic [ACC_BITS-1:0] rd_mod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mag_max_q <= MAG_MAX_RESET;
		else if (cfg_we)
			mag_max_q <= cfg_wdata;
	end

	tcp_front #(
		.ACC_BITS(ACC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.full    (full),
		.push    (push),
		.push_ctl(push_ctl),
		.push_mag(push_mag),
		.push_mod(push_mod)
	);

	tcp_fifo #(
		.W(QW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data({push_ctl, push_mag, push_mod}),
		.pop    (pop),
		.rd_data(rd_data),
		.full   (full),
		.empty  (empty)
	);

	assign rd_ctl = tcp_ctl_t'(rd_data[QW-1 -: $bits(tcp_ctl_t)]);
	assign rd_mag = rd_data[2*ACC_BITS-1 -: ACC_BITS];
	assign rd_mod = rd_data[ACC_BITS-1:0];

	tcp_back #(
		.ACC_BITS(ACC_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.pop     (pop),
		.rd_ctl  (rd_ctl),
		.rd_mag  (rd_mag),
		.rd_mod  (rd_mod),
		.mag_max (mag_max_q),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

// File: sim/tcp_cmd_checker.sv
`timescale 1ns / 1ps
// Checker for the text command parser: follows the byte, result and configuration channels,
// predicts the command each token causes and compares it with the result words.
// Depends on tcp_pkg.
module tcp_cmd_checker
	import tcp_pkg::*;
#(
	parameter int ACC_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	input  logic        s_tlast,   // frame_end
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // position [16:0], move_ms [36:17], zero fill
	input  logic [2:0]  m_tuser,   // cmd_kind
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata, // magnitude_max
	output int          errors,
	output int          pending,
	output int          checked
);

	typedef enum logic [3:0] {
		P_IDLE, P_SKIP, P_LCHAN, P_LMAG, P_LMOD, P_LTAIL, P_DSECOND, P_DMATCH, P_DREST
	} parse_phase_t;

	typedef enum logic [1:0] {TOKEN_NONE, TOKEN_DEVICE, TOKEN_LINEAR} token_kind_t;
	typedef enum logic [1:0] {QUERY_NONE, QUERY_DEVICE, QUERY_VERSION, QUERY_AXES} query_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [16:0] position;
		logic [19:0] duration;
	} command_t;

	localparam logic [63:0] ACC_MAX   = (64'd1 << ACC_BITS) - 64'd1;
	localparam logic [39:0] STOP_WORD = "DSTOP";

	parse_phase_t phase;
	token_kind_t  tok_kind;
	query_t       query;
	mod_kind_t    mod_kind;
	logic [2:0]   stop_count;
	logic [63:0]  mag_acc;
	logic [63:0]  mod_acc;
	logic         have_digit;
	logic [19:0]  mag_max;
	command_t     commands_due[$];
	int           err_cnt;
	int           chk_cnt;

	function automatic logic [63:0] push_digit(input logic [63:0] acc, input logic [7:0] c);
		logic [63:0] v;
		v = acc * 64'd10 + 64'(c - 8'h30);
		return (v > ACC_MAX) ? ACC_MAX : v;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	task automatic clear_token();
		phase = P_IDLE;
		tok_kind = TOKEN_NONE;
		query = QUERY_NONE;
		mod_kind = MOD_NONE;
		stop_count = '0;
		mag_acc = '0;
		mod_acc = '0;
		have_digit = 1'b0;
	endtask

	task automatic end_token();
		command_t    cmd;
		logic [63:0] mx;
		logic [63:0] pos;
		logic [63:0] dur;
		cmd = '{kind: KIND_LINEAR, position: '0, duration: '0};
		if (tok_kind == TOKEN_DEVICE) begin
			if (stop_count == STOP_LEN) begin
				cmd.kind = KIND_STOP;
				commands_due.push_back(cmd);
			end else if (query != QUERY_NONE) begin
				case (query)
					QUERY_DEVICE:  cmd.kind = KIND_DEVICE;
					QUERY_VERSION: cmd.kind = KIND_VERSION;
					default:       cmd.kind = KIND_AXES;
				endcase
				commands_due.push_back(cmd);
			end
		end else if (tok_kind == TOKEN_LINEAR && phase != P_SKIP && phase != P_LCHAN
				&& have_digit) begin
			mx = (mag_max == '0) ? 64'd1 : 64'(mag_max);
			pos = (mag_acc * 64'd131072 + mx) / (64'd2 * mx);
			if (pos > 64'(FULL_Q16))
				pos = 64'(FULL_Q16);
			dur = '0;
			if (mod_kind == MOD_INTERVAL)
				dur = (mod_acc > 64'(DUR_MAX)) ? 64'(DUR_MAX) : mod_acc;
			else if (mod_kind == MOD_SPEED && mod_acc != '0)
				dur = 64'(SPEED_NUM) / mod_acc;
			cmd.position = pos[16:0];
			cmd.duration = dur[19:0];
			commands_due.push_back(cmd);
		end
		clear_token();
	endtask

	task automatic take_char(input logic [7:0] c);
		logic [7:0] u;
		u = to_upper(c);
		case (phase)
			P_IDLE: begin
				if (u == "D") begin
					tok_kind = TOKEN_DEVICE;
					stop_count = 3'd1;
					phase = P_DSECOND;
				end else if (u == "L") begin
					tok_kind = TOKEN_LINEAR;
					phase = P_LCHAN;
				end else begin
					tok_kind = TOKEN_NONE;
					phase = P_SKIP;
				end
			end
			P_LCHAN: phase = (c == "0") ? P_LMAG : P_SKIP;
			P_LMAG: begin
				if (is_digit(c)) begin
					mag_acc = push_digit(mag_acc, c);
					have_digit = 1'b1;
				end else if (u == "I") begin
					mod_kind = MOD_INTERVAL;
					phase = P_LMOD;
				end else if (u == "S") begin
					mod_kind = MOD_SPEED;
					phase = P_LMOD;
				end else begin
					phase = P_LTAIL;
				end
			end
			P_LMOD: begin
				if (is_digit(c))
					mod_acc = push_digit(mod_acc, c);
				else
					phase = P_LTAIL;
			end
			P_DSECOND: begin
				if (u == "S") begin
					stop_count = 3'd2;
					phase = P_DMATCH;
				end else begin
					case (c)
						"0": query = QUERY_DEVICE;
						"1": query = QUERY_VERSION;
						"2": query = QUERY_AXES;
						default: ;
					endcase
					phase = P_DREST;
				end
			end
			P_DMATCH: begin
				if (stop_count < STOP_LEN && u == STOP_WORD[39 - 8 * stop_count -: 8]) begin
					stop_count = stop_count + 3'd1;
					if (stop_count == STOP_LEN)
						phase = P_DREST;
				end else begin
					phase = P_DREST;
				end
			end
			default: ;
		endcase
	endtask

	task automatic take_word(input logic [7:0] c, input logic fe);
		if (c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
			if (phase != P_IDLE)
				end_token();
		end else begin
			take_char(c);
			if (fe)
				end_token();
		end
	endtask

	task automatic report(input string field, input longint want, input longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		err_cnt++;
	endtask

	task automatic check_word();
		command_t cmd;
		if (commands_due.size() == 0) begin
			$display("%0t: unexpected result word, expected none, actual kind %0d tdata %h",
				$time, m_tuser, m_tdata);
			err_cnt++;
		end else begin
			cmd = commands_due.pop_front();
			if (m_tuser !== cmd.kind)
				report("cmd_kind", cmd.kind, m_tuser);
			if (m_tdata[16:0] !== cmd.position)
				report("position", cmd.position, m_tdata[16:0]);
			if (m_tdata[36:17] !== cmd.duration)
				report("move_ms", cmd.duration, m_tdata[36:17]);
			chk_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_token();
			mag_max = MAG_MAX_RESET;
			commands_due.delete();
			err_cnt = 0;
			chk_cnt = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (cfg_we)
				mag_max = cfg_wdata;
			if (s_tvalid && s_tready)
				take_word(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_word();
			errors <= err_cnt;
			pending <= commands_due.size();
			checked <= chk_cnt;
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for the text command parser: clock, reset, byte stimulus, result back-pressure
// and magnitude_max writes. Depends on tcp_pkg, tcp_cmd_checker and tcode_command_parser_core.
module tb;
	import tcp_pkg::*;

	localparam int ACC_BITS     = 20;
	localparam int MOVE_CYCLES  = 2 * (ACC_BITS + 18) + 3;
	localparam int RANDOM_BYTES = 700;
	localparam int PHASE_BYTES  = 140;

	localparam logic [7:0]  CH_SPACE  = 8'h20;
	localparam logic [7:0]  CH_TAB    = 8'h09;
	localparam logic [7:0]  CH_CR     = 8'h0D;
	localparam logic [7:0]  CH_LF     = 8'h0A;
	localparam logic [31:0] STOP_TAIL = "STOP";

	typedef enum int {END_SPACE, END_TAB, END_CR, END_LF, END_FRAME, END_FLAGGED} token_end_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_we;
	logic [19:0] cfg_wdata;
	int          errors;
	int          pending;
	int          checked;
	logic [7:0]  token_text[$];
	bit          quiet;
	int          bytes_sent;
	int          settings_used;

	tcode_command_parser_core #(.ACC_BITS(ACC_BITS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	tcp_cmd_checker #(.ACC_BITS(ACC_BITS)) u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb: FAIL");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [7:0] any_case(input logic [7:0] c);
		return ($urandom_range(0, 1) != 0) ? (c | 8'h20) : c;
	endfunction

	function automatic logic [7:0] rand_text_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF);
		return c;
	endfunction

	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			stall = quiet ? 0 : gap_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	task automatic send_word(input logic [7:0] ch, input logic fe);
		int gap;
		gap = quiet ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= fe;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_token(input token_end_t how);
		logic [7:0] delim;
		for (int i = 0; i < token_text.size(); i++)
			send_word(token_text[i], how == END_FRAME && i == token_text.size() - 1);
		if (how != END_FRAME) begin
			case (how)
				END_SPACE: delim = CH_SPACE;
				END_TAB:   delim = CH_TAB;
				END_CR:    delim = CH_CR;
				END_LF:    delim = CH_LF;
				default: begin
					case ($urandom_range(0, 3))
						0: delim = CH_SPACE;
						1: delim = CH_TAB;
						2: delim = CH_CR;
						default: delim = CH_LF;
					endcase
				end
			endcase
			send_word(delim, how == END_FLAGGED);
		end
		token_text.delete();
	endtask

	task automatic send_str(input string s, input token_end_t how);
		for (int i = 0; i < s.len(); i++)
			token_text.push_back(s[i]);
		send_token(how);
	endtask

	task automatic push_digits(input int n);
		repeat (n) token_text.push_back(8'h30 + 8'($urandom_range(0, 9)));
	endtask

	// Waits for every expected command, then for the back end to go quiet, then writes.
	task automatic set_magnitude_max(input logic [19:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (MOVE_CYCLES + 16) @(posedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic build_random_token();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			token_text.push_back(any_case("L"));
			if ($urandom_range(0, 19) == 0)
				token_text.push_back(($urandom_range(0, 1) != 0) ?
					8'h31 + 8'($urandom_range(0, 8)) : rand_text_byte());
			else
				token_text.push_back("0");
			if ($urandom_range(0, 11) == 0)
				push_digits(0);
			else if ($urandom_range(0, 9) == 0)
				push_digits($urandom_range(5, 9));
			else
				push_digits($urandom_range(1, 4));
			case ($urandom_range(0, 2))
				1: token_text.push_back(any_case("I"));
				2: token_text.push_back(any_case("S"));
				default: ;
			endcase
			if ($urandom_range(0, 9) == 0)
				token_text.push_back(($urandom_range(0, 1) != 0) ? "-" : "+");
			push_digits(($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 4));
			if ($urandom_range(0, 9) == 0) begin
				token_text.push_back("x");
				repeat ($urandom_range(0, 3)) token_text.push_back(rand_text_byte());
			end
		end else if (pick < 70) begin
			token_text.push_back(any_case("D"));
			case ($urandom_range(0, 4))
				0: begin
					for (int i = 0; i < 4; i++)
						token_text.push_back(any_case(STOP_TAIL[31 - 8 * i -: 8]));
					repeat ($urandom_range(0, 2)) token_text.push_back(rand_text_byte());
				end
				1: begin
					for (int i = 0; i < $urandom_range(1, 3); i++)
						token_text.push_back(any_case(STOP_TAIL[31 - 8 * i -: 8]));
					repeat ($urandom_range(0, 1)) token_text.push_back(rand_text_byte());
				end
				2: begin
					token_text.push_back(8'h30 + 8'($urandom_range(0, 2)));
					repeat ($urandom_range(0, 2)) token_text.push_back(rand_text_byte());
				end
				3: token_text.push_back(rand_text_byte());
				default: ;
			endcase
		end else if (pick < 85) begin
			token_text.push_back(any_case("L"));
			repeat ($urandom_range(0, 4)) token_text.push_back(rand_text_byte());
		end else begin
			repeat ($urandom_range(1, 6)) token_text.push_back(rand_text_byte());
		end
	endtask

	initial begin
		int         phase_no;
		int         phase_end;
		int         goal;
		int         r;
		token_end_t how;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		quiet = 1'b0;
		bytes_sent = 0;
		settings_used = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed tokens at the reset value of magnitude_max.
		send_str("DSTOP", END_FRAME);
		send_str("dsToPx", END_SPACE);
		send_str("DST", END_TAB);
		send_str("d0", END_LF);
		send_str("D1", END_CR);
		send_str("D2x", END_SPACE);
		send_str("D3", END_SPACE);
		send_str("L0999", END_SPACE);
		send_str("l00", END_FRAME);
		send_str("L0123456789", END_SPACE);
		send_str("L0500I1000", END_LF);
		send_str("L0500s50", END_FRAME);
		send_str("L0500S0", END_SPACE);
		send_str("L0500S1", END_SPACE);
		send_str("L0500S", END_SPACE);
		send_str("L0500I-5", END_SPACE);
		send_str("L0500i99999999", END_SPACE);
		send_str("L07x45", END_SPACE);
		send_str("L0I5", END_SPACE);
		send_str("L1500", END_SPACE);
		send_str("R0500", END_SPACE);
		send_str("L", END_FRAME);
		send_str("L0", END_FRAME);
		send_str("L077", END_FLAGGED);
		token_text = {8'h00, 8'hFF, 8'h80};
		send_token(END_SPACE);

		goal = bytes_sent + RANDOM_BYTES;
		phase_no = 0;
		while (bytes_sent < goal) begin
			case (phase_no % 6)
				0: set_magnitude_max(20'd1);
				1: set_magnitude_max(20'hFFFFF);
				2: set_magnitude_max(20'd0);
				3: set_magnitude_max(20'($urandom_range(1, 2000)));
				4: set_magnitude_max(20'($urandom_range(1, 20'hFFFFF)));
				default: set_magnitude_max(MAG_MAX_RESET);
			endcase
			quiet = (phase_no == 3);
			phase_end = bytes_sent + PHASE_BYTES;
			while (bytes_sent < phase_end && bytes_sent < goal) begin
				build_random_token();
				r = $urandom_range(0, 99);
				if (r < 30)
					how = END_SPACE;
				else if (r < 40)
					how = END_TAB;
				else if (r < 50)
					how = END_CR;
				else if (r < 65)
					how = END_LF;
				else if (r < 88)
					how = END_FRAME;
				else
					how = END_FLAGGED;
				send_token(how);
				if ($urandom_range(0, 11) == 0)
					send_word(CH_SPACE, 1'($urandom_range(0, 1)));
			end
			phase_no++;
		end
		quiet = 1'b0;

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2 * MOVE_CYCLES) @(posedge clk);
		$display("summary: %0d bytes sent, %0d commands checked, %0d magnitude_max settings",
			bytes_sent, checked, settings_used);
		$display("summary: stop, queries, moves with interval and speed, noise and frame ends");
		if (errors == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
